[rtl/soft_timer_bank_defines.svh]
// Assertion macros for the soft timer bank.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SOFT_TIMER_BANK_DEFINES_SVH
`define SOFT_TIMER_BANK_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define STB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, disabled while in reset
`define STB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define STB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/stb_pkg.sv]
// Shared types and fixed widths for the soft timer bank.
// No dependencies; imported by the interfaces, the timer core and the top level.
`default_nettype none

package stb_pkg;

	localparam int OP_W    = 2;
	localparam int SLOT_W  = 4;
	localparam int DUR_W   = 16;
	localparam int MASK_W  = 8;
	localparam int TICK_W  = 32;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	// requests from the top level to the timer core
	typedef struct packed {
		logic go_tick;
		logic go_start;
	} stb_req_t;

	// status from the timer core
	typedef struct packed {
		logic busy;
	} stb_stat_t;

endpackage

`default_nettype wire

[rtl/stb_ifs.sv]
// Valid/ready channel interfaces for the soft timer bank: command and response words.
// Depends on stb_pkg.
`default_nettype none

interface stb_cmd_if import stb_pkg::*; ;
	logic                 valid;
	logic                 ready;
	op_t                  op;
	logic [SLOT_W-1:0]    slot;
	logic [DUR_W-1:0]     duration;

	modport source (output valid, output op, output slot, output duration, input ready);
	modport sink   (input valid, input op, input slot, input duration, output ready);
endinterface

interface stb_rsp_if import stb_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic                 expired;
	logic [MASK_W-1:0]    expired_mask;
	logic [TICK_W-1:0]    tick_count;

	modport source (output valid, output expired, output expired_mask, output tick_count,
		input ready);
	modport sink   (input valid, input expired, input expired_mask, input tick_count,
		output ready);
endinterface

`default_nettype wire

[rtl/soft_timer_bank.sv]
// Top level of the soft timer bank: command/response handshake, tick counter,
// result register. Depends on stb_pkg, stb_ifs, stb_timer_core and the defines header.
//
//   channel | modport     | word fields
//   --------+-------------+--------------------------------------------
//   cmd     | stb_cmd_if  | op, slot, duration        (sink)
//   rsp     | stb_rsp_if  | expired, expired_mask, tick_count (source)
//
// Order: start, query and unused op go from idle straight to the final state on
//   the accept, a tick through the walk state over slots 1..NUM_SLOTS-1 via the
//   one decrementer and the registered count read; the result register loads as
//   the final state returns to idle, where the next word can be taken.
// One word is in work at a time; cmd.ready is high only while idle.
// The result register lets the next word be taken while a response waits;
//   a finished word holds in the final state until the register is free.
// Reset (arst_n, asynchronous, active low) clears flags, tick counter and
//   control; the count memory is not cleared, its contents are only used for armed slots.
`default_nettype none
`include "soft_timer_bank_defines.svh"

module soft_timer_bank import stb_pkg::*; #(
	parameter int NUM_SLOTS  = 8,
	parameter int COUNT_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	stb_cmd_if.sink    cmd,
	stb_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam logic [31:0] LAST_SLOT = 32'(NUM_SLOTS - 1);
	localparam logic [31:0] SLOT_CNT  = 32'(NUM_SLOTS);

	state_t                state_q;
	logic [TICK_W-1:0]     ticks_q;
	logic                  exp_q;
	logic                  out_vld_q;
	logic                  out_exp_q;
	logic [MASK_W-1:0]     out_mask_q;
	logic [TICK_W-1:0]     out_ticks_q;

	logic                  accept;
	logic                  out_free;
	logic [31:0]           slot_ext;
	logic [31:0]           dur_ext;
	logic [IDX_W-1:0]      start_slot;
	logic [COUNT_BITS-1:0] start_count;
	logic                  query_bit;
	logic [63:0]           flags_ext;
	stb_req_t              req;
	stb_stat_t             stat;
	logic [NUM_SLOTS-1:0]  expired_flags;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_vld_q || rsp.ready;

	// slot saturates to the last slot for a start; zero count loads as one
	assign slot_ext   = 32'(cmd.slot);
	assign dur_ext    = 32'(cmd.duration);
	assign start_slot = (slot_ext > LAST_SLOT) ? LAST_SLOT[IDX_W-1:0] : slot_ext[IDX_W-1:0];
	always_comb begin
		start_count = dur_ext[COUNT_BITS-1:0];
		if (start_count == '0) begin
			start_count = COUNT_BITS'(1);
		end
	end

	// out-of-range query reads zero
	assign query_bit = (slot_ext < SLOT_CNT) ? expired_flags[slot_ext[IDX_W-1:0]] : 1'b0;

	assign req.go_tick  = accept && (cmd.op == OP_TICK);
	assign req.go_start = accept && (cmd.op == OP_START);

	stb_timer_core #(
		.NUM_SLOTS  (NUM_SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.start_slot    (start_slot),
		.start_count   (start_count),
		.stat          (stat),
		.expired_flags (expired_flags)
	);

	assign flags_ext = 64'(expired_flags);

	// sequencer and tick counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ticks_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.op == OP_TICK) begin
							ticks_q <= ticks_q + TICK_W'(1);
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_WALK: begin
					if (!stat.busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query result held from accept; flags do not move for a query
	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= (cmd.op == OP_QUERY) ? query_bit : 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_exp_q   <= exp_q;
			out_mask_q  <= flags_ext[MASK_W-1:0];
			out_ticks_q <= ticks_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.expired      = out_exp_q;
	assign rsp.expired_mask = out_mask_q;
	assign rsp.tick_count   = out_ticks_q;

	`STB_ASSERT_NXT(a_fin_loads, clk, arst_n, (state_q == ST_FIN && out_free), (out_vld_q && state_q == ST_IDLE), "finished word not loaded")
	`STB_ASSERT_IMP(a_idle_quiet, clk, arst_n, (state_q == ST_IDLE), !stat.busy, "core busy while idle")
	`STB_ASSERT_NXT(a_tick_count, clk, arst_n, req.go_tick, (ticks_q == $past(ticks_q) + TICK_W'(1)), "tick counter did not advance")
	`STB_ASSERT_NXT(a_walk_busy, clk, arst_n, req.go_tick, stat.busy, "walk did not start")

endmodule

`default_nettype wire

[rtl/stb_timer_core.sv]
// Timer slot store: count memory, armed and expired flags, and the tick walker
// that decrements armed slots >0 in one shared decrementer. Depends on stb_pkg.
`default_nettype none
`include "soft_timer_bank_defines.svh"

module stb_timer_core import stb_pkg::*; #(
	parameter int NUM_SLOTS  = 8,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire stb_req_t                     req,
	input  wire logic [$clog2(NUM_SLOTS)-1:0] start_slot,
	input  wire logic [COUNT_BITS-1:0]        start_count,
	output stb_stat_t                         stat,
	output logic [NUM_SLOTS-1:0]              expired_flags
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
	localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

	logic [COUNT_BITS-1:0] rem_mem [NUM_SLOTS];

	logic [NUM_SLOTS-1:0]  armed_q;
	logic [NUM_SLOTS-1:0]  expired_q;
	logic                  rd_act_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [COUNT_BITS-1:0] rd_data_s1;

	logic [COUNT_BITS-1:0] dec_val;
	logic                  dec_en;
	logic                  dec_zero;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;

	// shared decrementer
	assign dec_val  = rd_data_s1 - COUNT_BITS'(1);
	assign dec_en   = rd_vld_s1 && armed_q[idx_s1];
	assign dec_zero = (dec_val == '0);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = start_slot;
		mem_wdata = start_count;
		if (req.go_start) begin
			mem_we = 1'b1;
		end else if (dec_en) begin
			mem_we    = 1'b1;
			mem_waddr = idx_s1;
			mem_wdata = dec_val;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rem_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_act_q) begin
			rd_data_s1 <= rem_mem[rd_idx_q];
			idx_s1     <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q  <= 1'b0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_act_q;
			if (req.go_tick) begin
				rd_act_q <= 1'b1;
				rd_idx_q <= FIRST_IDX;
			end else if (rd_act_q) begin
				if (rd_idx_q == LAST_IDX) begin
					rd_act_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= '0;
			expired_q <= '0;
		end else begin
			if (req.go_start) begin
				armed_q[start_slot]   <= 1'b1;
				expired_q[start_slot] <= 1'b0;
			end else if (dec_en && dec_zero) begin
				armed_q[idx_s1]   <= 1'b0;
				expired_q[idx_s1] <= 1'b1;
			end
		end
	end

	assign stat.busy     = rd_act_q | rd_vld_s1;
	assign expired_flags = expired_q;

	`STB_ASSERT_IMP(a_arm_excl, clk, arst_n, 1'b1, ((armed_q & expired_q) == '0), "slot both armed and expired")
	`STB_ASSERT_IMP(a_slot0_never, clk, arst_n, 1'b1, (expired_q[0] == 1'b0), "slot zero expired")
	`STB_ASSERT_IMP(a_no_start_walk, clk, arst_n, stat.busy, (!req.go_start && !req.go_tick), "request while walking")

endmodule

`default_nettype wire

[tb/stb_bank_checker.sv]
// Response checker for the soft timer bank: watches the command and response channels,
// keeps its own copy of the timer bank and compares every response word in order.
// Depends on stb_pkg and the channel interfaces in stb_ifs.
module stb_bank_checker import stb_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	stb_cmd_if          cmd,
	stb_rsp_if          rsp,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned checked,
	output int unsigned expiries
);

	localparam int NUM_SLOTS    = MASK_W;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic              expired;
		logic [MASK_W-1:0] mask;
		logic [TICK_W-1:0] ticks;
	} bank_status_t;

	logic [NUM_SLOTS-1:0] armed;
	logic [NUM_SLOTS-1:0] flags;
	logic [DUR_W-1:0]     remaining [NUM_SLOTS];
	logic [TICK_W-1:0]    ticks;
	bank_status_t         due_status [$];

	// apply one command word to the local bank, return the status word it should produce
	task automatic advance_bank(input op_t op, input logic [SLOT_W-1:0] slot,
		input logic [DUR_W-1:0] duration, output bank_status_t st);
		int unsigned idx;
		st.expired = 1'b0;
		case (op)
		OP_TICK: begin
			ticks = ticks + 1'b1;
			// slot 0 is never counted down
			for (int k = 1; k < NUM_SLOTS; k++) begin
				if (armed[k]) begin
					remaining[k] = remaining[k] - 1'b1;
					if (remaining[k] == '0) begin
						flags[k] = 1'b1;
						armed[k] = 1'b0;
						expiries++;
					end
				end
			end
		end
		OP_START: begin
			idx = (slot > NUM_SLOTS - 1) ? NUM_SLOTS - 1 : slot;
			armed[idx]     = 1'b1;
			remaining[idx] = (duration == '0) ? DUR_W'(1) : duration;
			flags[idx]     = 1'b0;
		end
		OP_QUERY: begin
			if (slot < NUM_SLOTS)
				st.expired = flags[slot];
		end
		default: ;
		endcase
		st.mask  = flags;
		st.ticks = ticks;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bank_status_t got;
		bank_status_t want;
		if (!arst_n) begin
			armed      = '0;
			flags      = '0;
			ticks      = '0;
			for (int k = 0; k < NUM_SLOTS; k++)
				remaining[k] = '0;
			due_status.delete();
			fail_count = 0;
			pending    = 0;
			checked    = 0;
			expiries   = 0;
		end else begin
			// compare first: a word accepted this edge cannot be answered on the same edge
			if (rsp.valid && rsp.ready) begin
				got = {rsp.expired, rsp.expired_mask, rsp.tick_count};
				checked++;
				if (due_status.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: unexpected response expired=%0b mask=%02h ticks=%0d",
							$realtime, got.expired, got.mask, got.ticks);
				end else begin
					want = due_status.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display({"%0t: mismatch: expected expired=%0b mask=%02h ticks=%0d,",
								" got expired=%0b mask=%02h ticks=%0d"}, $realtime,
								want.expired, want.mask, want.ticks,
								got.expired, got.mask, got.ticks);
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				advance_bank(cmd.op, cmd.slot, cmd.duration, want);
				due_status.push_back(want);
			end
			pending = due_status.size();
		end
	end

endmodule

[tb/tb.sv]
// Testbench top for the soft timer bank: clock, reset, command stimulus, response
// back-pressure, watchdog and verdict. Depends on stb_pkg, stb_ifs, the RTL and stb_bank_checker.
module tb;
	import stb_pkg::*;

	// no handshake on either channel in this many cycles means the block has hung;
	// the slowest word is a tick with its slot walk, plus sender gaps and receiver stalls
	localparam int WATCHDOG_CYCLES = 2000;
	// settling time after the last response
	localparam int DRAIN_CYCLES    = 20;
	// non-ignored random words per handshake phase
	localparam int PHASE_WORDS     = 180;

	logic clk;
	logic arst_n;

	stb_cmd_if cmd_ch ();
	stb_rsp_if rsp_ch ();

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked;
	int unsigned expiries;

	// throttle percentages, changed per phase by the stimulus process
	int unsigned tx_gap_pct;
	int unsigned rx_stall_pct;

	int unsigned n_tick;
	int unsigned n_start;
	int unsigned n_query;
	int unsigned n_unused;

	soft_timer_bank uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	stb_bank_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.expiries   (expiries)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// response back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		rsp_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
	end

	// one command word: optional idle gap, then hold valid until the block takes it.
	// Entered and left at a falling edge; valid stays high on return so back-to-back
	// words need no extra cycle.
	task automatic send_word(input op_t op, input logic [SLOT_W-1:0] slot,
		input logic [DUR_W-1:0] duration);
		while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.op       <= op;
		cmd_ch.slot     <= slot;
		cmd_ch.duration <= duration;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
		case (op)
		OP_TICK:  n_tick++;
		OP_START: n_start++;
		OP_QUERY: n_query++;
		default:  n_unused++;
		endcase
	endtask

	// sender holds off until every outstanding response has come back
	task automatic wait_until_settled();
		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// random word, weighted towards short timers so that expiries happen often;
	// tick and query still carry random slot and duration to toggle every bit
	task automatic send_random();
		int unsigned pick;
		op_t op;
		logic [SLOT_W-1:0] slot;
		logic [DUR_W-1:0] duration;
		pick     = $urandom_range(99);
		slot     = SLOT_W'($urandom_range(15));
		duration = DUR_W'($urandom);
		if (pick < 40) begin
			op = OP_TICK;
		end else if (pick < 68) begin
			op = OP_START;
			// mostly real slots, some out of range to hit saturation
			if ($urandom_range(99) < 85)
				slot = SLOT_W'($urandom_range(7));
			pick = $urandom_range(99);
			if (pick < 80)
				duration = DUR_W'($urandom_range(12));
			else if (pick < 95)
				duration = DUR_W'($urandom_range(100, 13));
		end else if (pick < 93) begin
			op = OP_QUERY;
			if ($urandom_range(99) < 85)
				slot = SLOT_W'($urandom_range(7));
		end else begin
			op = OP_NONE;
		end
		send_word(op, slot, duration);
	endtask

	// hang detector: counts cycles with no handshake on either channel
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles, %0d responses outstanding",
			WATCHDOG_CYCLES, pending);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int unsigned target;
		cmd_ch.valid    = 1'b0;
		cmd_ch.op       = OP_TICK;
		cmd_ch.slot     = '0;
		cmd_ch.duration = '0;
		rsp_ch.ready    = 1'b0;
		tx_gap_pct      = 0;
		rx_stall_pct    = 0;
		n_tick          = 0;
		n_start         = 0;
		n_query         = 0;
		n_unused        = 0;
		arst_n          = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, no throttling
		send_word(OP_QUERY, 4'd0,  16'h0000);  // flags clear after reset
		send_word(OP_NONE,  4'd15, 16'hFFFF);  // unused op changes nothing
		send_word(OP_START, 4'd0,  16'h0000);  // slot 0 arms but never counts
		send_word(OP_START, 4'd15, 16'hFFFF);  // out-of-range slot lands on 7, max count
		send_word(OP_START, 4'd3,  16'h0000);  // zero duration loads as one
		send_word(OP_START, 4'd1,  16'h0002);
		send_word(OP_START, 4'd2,  16'h0005);
		send_word(OP_TICK,  4'd9,  16'hA5A5);  // slot 3 expires
		send_word(OP_QUERY, 4'd3,  16'h0000);
		send_word(OP_QUERY, 4'd15, 16'h0000);  // beyond the bank reads 0
		send_word(OP_QUERY, 4'd8,  16'h0000);
		send_word(OP_START, 4'd2,  16'h0001);  // restart while armed reloads the count
		send_word(OP_TICK,  4'd0,  16'h0000);  // slots 1 and 2 expire together
		send_word(OP_QUERY, 4'd0,  16'h0000);  // slot 0 still armed, not expired
		send_word(OP_START, 4'd3,  16'h0003);  // restart after expiry clears the flag
		send_word(OP_QUERY, 4'd3,  16'hFFFF);
		send_word(OP_TICK,  4'd15, 16'h5A5A);
		send_word(OP_TICK,  4'd6,  16'h0000);
		send_word(OP_TICK,  4'd0,  16'hFFFF);  // slot 3 expires again
		send_word(OP_QUERY, 4'd7,  16'h0000);  // long timer still running
		send_word(OP_START, 4'd4,  16'h8000);
		send_word(OP_NONE,  4'd0,  16'h0000);
		wait_until_settled();

		// random part: unthrottled, sender gaps, receiver stalls, then both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_gap_pct = 51; rx_stall_pct = 0;  end
			2: begin tx_gap_pct = 0;  rx_stall_pct = 51; end
			default: begin tx_gap_pct = 33; rx_stall_pct = 33; end
			endcase
			// ignored words do not count towards the phase
			target = n_tick + n_start + n_query + PHASE_WORDS;
			while (n_tick + n_start + n_query < target)
				send_random();
			wait_until_settled();
		end
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d command words: %0d ticks, %0d starts, %0d queries, %0d unused ops,",
			n_tick + n_start + n_query + n_unused, n_tick, n_start, n_query, n_unused);
		$display("under four throttle mixes; %0d responses compared, %0d timer expiries seen.",
			checked, expiries);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d response words wrong or unexpected", fail_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[soft_timer_bank.f]
+incdir+rtl
rtl/stb_pkg.sv
rtl/stb_ifs.sv
rtl/stb_timer_core.sv
rtl/soft_timer_bank.sv
tb/stb_bank_checker.sv
tb/tb.sv
